FILE: sv/ssmp_pkg.sv
`default_nettype none

package ssmp_pkg;

    // Message layout
    localparam int HASH_BYTES   = 16;
    localparam int HEADER_BYTES = 1 + 1 + 2 + 4;
    localparam int FIELD_IDX_W  = 5;
    localparam int QLEN_BYTES   = 4;
    localparam int OLEN_BYTES   = 2;

    localparam logic [FIELD_IDX_W-1:0] HEADER_LAST_IDX = FIELD_IDX_W'(HEADER_BYTES - 1);
    localparam logic [FIELD_IDX_W-1:0] HASH_LAST_IDX   = FIELD_IDX_W'(HASH_BYTES - 1);
    localparam logic [FIELD_IDX_W-1:0] QLEN_LAST_IDX   = FIELD_IDX_W'(QLEN_BYTES - 1);
    localparam logic [FIELD_IDX_W-1:0] OLEN_LAST_IDX   = FIELD_IDX_W'(OLEN_BYTES - 1);

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_KIND       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_MASK_BITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAST_RESULT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOST_RESULT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAST_DEADLINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOST_DEADLINE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SIZE_CAP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS_SIZE_CAP   = 3'd7;

    // Result item kinds
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_HASH   = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_OPTION = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // End status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TOOLARGE  = 2'd3;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_HASH,
        PH_QLEN,
        PH_QUERY,
        PH_OLEN,
        PH_OPTS
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_data;
        logic       buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [7:0]  query_kind;
        logic [7:0]  net_mask;
        logic [15:0] result_limit;
        logic [31:0] timeout_msec;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [31:0] consumed_bytes;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  highest_kind;
        logic [7:0]  known_mask_bits;
        logic [15:0] least_result_limit;
        logic [15:0] most_result_limit;
        logic [31:0] least_deadline;
        logic [31:0] most_deadline;
        logic [31:0] query_size_cap;
        logic [15:0] options_size_cap;
    } t_cfg;

    function automatic t_out_word make_payload(logic [2:0] kind, logic [7:0] b);
        t_out_word w;
        w              = '0;
        w.item_kind    = kind;
        w.payload_byte = b;
        return w;
    endfunction

    function automatic t_out_word make_end(logic [1:0] st, logic [31:0] consumed);
        t_out_word w;
        w                = '0;
        w.item_kind      = KIND_END;
        w.status         = st;
        w.consumed_bytes = (st == ST_OK) ? consumed : 32'd0;
        w.last_result    = 1'b1;
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ssmp_cfg_regs.sv
`default_nettype none

module ssmp_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [ssmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [ssmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ssmp_pkg::t_cfg                   o_cfg
);
    import ssmp_pkg::*;

    t_cfg r_cfg;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.highest_kind       <= 8'd3;
            r_cfg.known_mask_bits    <= 8'd3;
            r_cfg.least_result_limit <= 16'd1;
            r_cfg.most_result_limit  <= 16'd1000;
            r_cfg.least_deadline     <= 32'd1000;
            r_cfg.most_deadline      <= 32'd120000;
            r_cfg.query_size_cap     <= 32'd1024;
            r_cfg.options_size_cap   <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIGHEST_KIND:       r_cfg.highest_kind       <= i_cfg_data[7:0];
                CFG_KNOWN_MASK_BITS:    r_cfg.known_mask_bits    <= i_cfg_data[7:0];
                CFG_LEAST_RESULT_LIMIT: r_cfg.least_result_limit <= i_cfg_data[15:0];
                CFG_MOST_RESULT_LIMIT:  r_cfg.most_result_limit  <= i_cfg_data[15:0];
                CFG_LEAST_DEADLINE:     r_cfg.least_deadline     <= i_cfg_data[31:0];
                CFG_MOST_DEADLINE:      r_cfg.most_deadline      <= i_cfg_data[31:0];
                CFG_QUERY_SIZE_CAP:     r_cfg.query_size_cap     <= i_cfg_data[31:0];
                CFG_OPTIONS_SIZE_CAP:   r_cfg.options_size_cap   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/ssmp_parser.sv
`default_nettype none

module ssmp_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_take,
    input  ssmp_pkg::t_in_word   i_word,
    input  ssmp_pkg::t_cfg       i_cfg,
    output logic [1:0]           o_push_n,
    output ssmp_pkg::t_out_word  o_res0,
    output ssmp_pkg::t_out_word  o_res1
);
    import ssmp_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [FIELD_IDX_W-1:0]  r_idx, n_idx;
    logic [63:0]             r_shift, n_shift;
    logic                    r_hash_nz, n_hash_nz;
    logic [31:0]             r_rem, n_rem;
    logic [31:0]             r_pos, n_pos;
    logic                    r_finished, n_finished;

    logic [63:0]  shift_in;
    logic [31:0]  pos_inc;
    logic         hash_nz_in;
    logic         hdr_ok;
    logic [31:0]  qlen;
    logic [15:0]  olen;
    logic         a_valid, b_valid;
    t_out_word    a_word, b_word;

    // Field bytes arrive little-endian: shift in from the top
    assign shift_in   = {i_word.data_byte, r_shift[63:8]};
    assign pos_inc    = (r_pos == 32'hFFFF_FFFF) ? r_pos : r_pos + 32'd1;
    assign hash_nz_in = r_hash_nz | (i_word.data_byte != 8'd0);
    assign qlen       = shift_in[63:32];
    assign olen       = shift_in[63:48];

    // Header range checks on the completed header
    assign hdr_ok = (shift_in[7:0] <= i_cfg.highest_kind)
                 && (shift_in[15:8] != 8'd0)
                 && ((shift_in[15:8] & ~i_cfg.known_mask_bits) == 8'd0)
                 && (shift_in[31:16] >= i_cfg.least_result_limit)
                 && (shift_in[31:16] <= i_cfg.most_result_limit)
                 && (shift_in[63:32] >= i_cfg.least_deadline)
                 && (shift_in[63:32] <= i_cfg.most_deadline);

    // Parse one word: a byte result or header first, then an end result
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_shift    = r_shift;
        n_hash_nz  = r_hash_nz;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_finished = r_finished;
        a_valid    = 1'b0;
        a_word     = '0;
        b_valid    = 1'b0;
        b_word     = '0;

        if (i_take) begin
            if (!r_finished && !i_word.no_data) begin
                n_shift = shift_in;
                n_pos   = pos_inc;
                case (r_phase)
                    PH_HEADER: begin
                        if (r_idx >= HEADER_LAST_IDX) begin
                            if (hdr_ok) begin
                                a_valid             = 1'b1;
                                a_word.item_kind    = KIND_HEADER;
                                a_word.query_kind   = shift_in[7:0];
                                a_word.net_mask     = shift_in[15:8];
                                a_word.result_limit = shift_in[31:16];
                                a_word.timeout_msec = shift_in[63:32];
                                n_phase             = PH_HASH;
                                n_idx               = '0;
                            end else begin
                                b_valid    = 1'b1;
                                b_word     = make_end(ST_MALFORMED, pos_inc);
                                n_finished = 1'b1;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_HASH: begin
                        a_valid   = 1'b1;
                        a_word    = make_payload(KIND_HASH, i_word.data_byte);
                        n_hash_nz = hash_nz_in;
                        if (r_idx >= HASH_LAST_IDX) begin
                            if (!hash_nz_in) begin
                                b_valid    = 1'b1;
                                b_word     = make_end(ST_MALFORMED, pos_inc);
                                n_finished = 1'b1;
                            end else begin
                                n_phase = PH_QLEN;
                                n_idx   = '0;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_QLEN: begin
                        if (r_idx >= QLEN_LAST_IDX) begin
                            if (qlen > i_cfg.query_size_cap) begin
                                b_valid    = 1'b1;
                                b_word     = make_end(ST_TOOLARGE, pos_inc);
                                n_finished = 1'b1;
                            end else begin
                                n_rem   = qlen;
                                n_phase = (qlen == 32'd0) ? PH_OLEN : PH_QUERY;
                                n_idx   = '0;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_QUERY: begin
                        a_valid = 1'b1;
                        a_word  = make_payload(KIND_QUERY, i_word.data_byte);
                        n_rem   = r_rem - 32'd1;
                        if (r_rem == 32'd1) begin
                            n_phase = PH_OLEN;
                            n_idx   = '0;
                        end
                    end
                    PH_OLEN: begin
                        if (r_idx >= OLEN_LAST_IDX) begin
                            if (olen > i_cfg.options_size_cap) begin
                                b_valid    = 1'b1;
                                b_word     = make_end(ST_TOOLARGE, pos_inc);
                                n_finished = 1'b1;
                            end else if (olen == 16'd0) begin
                                b_valid    = 1'b1;
                                b_word     = make_end(ST_OK, pos_inc);
                                n_finished = 1'b1;
                            end else begin
                                n_rem   = {16'd0, olen};
                                n_phase = PH_OPTS;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    PH_OPTS: begin
                        a_valid = 1'b1;
                        a_word  = make_payload(KIND_OPTION, i_word.data_byte);
                        n_rem   = r_rem - 32'd1;
                        if (r_rem == 32'd1) begin
                            b_valid    = 1'b1;
                            b_word     = make_end(ST_OK, pos_inc);
                            n_finished = 1'b1;
                        end
                    end
                    default: begin
                        n_phase    = PH_HEADER;
                        n_idx      = '0;
                        n_hash_nz  = 1'b0;
                        n_pos      = '0;
                        n_finished = 1'b0;
                    end
                endcase
            end

            // Close an open message at buffer end, then restart
            if (i_word.buffer_end) begin
                if (!n_finished) begin
                    b_valid = 1'b1;
                    b_word  = make_end(ST_TRUNC, 32'd0);
                end
                n_phase    = PH_HEADER;
                n_idx      = '0;
                n_hash_nz  = 1'b0;
                n_pos      = '0;
                n_finished = 1'b0;
            end
        end
    end

    // Pack results in order
    assign o_push_n = {1'b0, a_valid} + {1'b0, b_valid};
    assign o_res0   = a_valid ? a_word : b_word;
    assign o_res1   = b_word;

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_idx      <= '0;
            r_hash_nz  <= 1'b0;
            r_pos      <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_hash_nz  <= n_hash_nz;
            r_pos      <= n_pos;
            r_finished <= n_finished;
        end
    end

    // Field assembly and payload count need no reset
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

endmodule

`default_nettype wire

FILE: sv/ssmp_result_fifo.sv
`default_nettype none

module ssmp_result_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire [1:0]            i_push_n,
    input  ssmp_pkg::t_out_word  i_word0,
    input  ssmp_pkg::t_out_word  i_word1,
    input  wire                  i_stall,
    output logic                 o_valid,
    output ssmp_pkg::t_out_word  o_word,
    output logic                 o_no_room
);
    import ssmp_pkg::*;

    t_out_word               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    pop;
    logic [FIFO_PTR_W-1:0]   wr_ptr_1;

    assign o_valid   = (r_count != '0);
    assign o_word    = r_mem[r_rd_ptr];
    assign pop       = o_valid && !i_stall;
    assign wr_ptr_1  = r_wr_ptr + 1'b1;
    // Stall input unless two free slots remain
    assign o_no_room = (r_count > FIFO_CNT_W'(FIFO_DEPTH - 2));

    // Write up to two words per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_word0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr_1] <= i_word1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push_n) - FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: sv/search_start_message_parser.sv
// Result words are registered in the result queue before they are offered.
// Throughput: one input word per cycle while o_in_stall is low; a word causing two
// results writes both into the queue, to be offered one after the other, and input
// stalls while more than two results are queued in the four-entry result queue.
// Reset: synchronous, active low; clears parse state, the result queue and loads
// the register defaults.
`default_nettype none

module search_start_message_parser (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  ssmp_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output ssmp_pkg::t_out_word              o_out_word,
    input  wire                              i_cfg_we,
    input  wire [ssmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [ssmp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ssmp_pkg::*;

    t_cfg       cfg;
    logic       take;
    logic [1:0] push_n;
    t_out_word  res0, res1;

    assign take = i_in_valid && !o_in_stall;

    ssmp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssmp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .o_push_n (push_n),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    ssmp_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_n  (push_n),
        .i_word0   (res0),
        .i_word1   (res1),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_word    (o_out_word),
        .o_no_room (o_in_stall)
    );

    // Input stalls only while results are pending
    a_stall_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result queue");

    // Only end words close a message
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last_result) |-> (o_out_word.item_kind == KIND_END))
        else $error("last_result on a non-end word");

    // Failed messages report no consumed bytes
    a_fail_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.item_kind == KIND_END) && (o_out_word.status != ST_OK))
        |-> (o_out_word.consumed_bytes == 32'd0))
        else $error("nonzero consumed count on failed message");

endmodule

`default_nettype wire
